// ===== design/asd_pkg.sv =====
`default_nettype none
package asd_pkg;

    localparam int WINDOW_DEPTH_DEF     = 65536;
    localparam int BYTES_PER_RESULT_DEF = 4;
    localparam int NUM_LANES            = 4;
    localparam int CNT_W                = 21;
    localparam int LEN_W                = 7;
    localparam int BYTE_CNT_W           = 3;

    localparam logic [CNT_W-1:0] OUT_LIMIT_RST = 21'd65536;

    localparam logic [7:0] LIT_FLAG       = 8'h80;
    localparam logic [7:0] KIND_MASK      = 8'hc0;
    localparam logic [7:0] LIT_LEN_MASK   = 8'h7f;
    localparam logic [7:0] SHORT_LEN_MASK = 8'h3c;
    localparam logic [7:0] LONG_LEN_MASK  = 8'h3f;
    localparam logic [7:0] SHORT_OFF_MASK = 8'h03;
    localparam logic [7:0] SHORT_LEN_BIAS = 8'd3;
    localparam logic [7:0] LONG_LEN_BIAS  = 8'd4;

    typedef enum logic [1:0] {
        PH_CODE,
        PH_LIT,
        PH_OFFLO,
        PH_OFFHI
    } phase_t;

    typedef enum logic {
        ST_IDLE,
        ST_COPY
    } state_t;

    typedef struct packed {
        logic [CNT_W-1:0]           total;
        logic [BYTE_CNT_W-1:0]      count;
        logic                       run_last;
        logic                       block_done;
        logic [NUM_LANES-1:0][7:0]  bytes;
    } result_t;

endpackage
`default_nettype wire

// ===== design/asd_ram.sv =====
`default_nettype none
module asd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== design/adc_stream_decompressor_core.sv =====
`default_nettype none
// ADC stream decoder: one compressed byte per input beat, decoded bytes leave packed up to
// four per output beat. A match copies one byte a cycle through the history RAM (one write
// port, one read port with a registered read) while the output beat is taken; no input
// byte is taken until the copy is done. The history needs no clearing after reset;
// out_limit caps the bytes of one block and the beat with tlast ends the block with
// block_done set and the total count.
module adc_stream_decompressor_core
    import asd_pkg::*;
#(
    parameter int WINDOW_DEPTH     = WINDOW_DEPTH_DEF,
    parameter int BYTES_PER_RESULT = BYTES_PER_RESULT_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_wr_en,
    input  wire logic [CNT_W-1:0]  cfg_wr_data,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [7:0]        s_axis_tdata,   // in_byte
    input  wire logic              s_axis_tlast,   // in_last
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [55:0]            m_axis_tdata,   // byte0, byte1, byte2, byte3, count, total
    output logic                   m_axis_tlast,   // run_last
    output logic                   m_axis_tuser    // block_done
);

    localparam int PER = (BYTES_PER_RESULT > NUM_LANES) ? NUM_LANES :
                         ((BYTES_PER_RESULT < 1) ? 1 : BYTES_PER_RESULT);
    localparam logic [BYTE_CNT_W-1:0] PER_CNT = BYTE_CNT_W'(PER);
    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam logic [AW-1:0] WP_MAX = AW'(WINDOW_DEPTH - 1);
    localparam logic [AW:0] DEPTH_EXT = (AW+1)'(WINDOW_DEPTH);

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
        return (a == WP_MAX) ? '0 : a + 1'b1;
    endfunction

    state_t                    state_reg, state_next;
    phase_t                    phase_reg, phase_next;
    logic [LEN_W-1:0]          lit_left_reg, lit_left_next;
    logic [LEN_W-1:0]          match_len_reg, match_len_next;
    logic [7:0]                off_high_reg, off_high_next;
    logic [CNT_W-1:0]          written_reg, written_next;
    logic [CNT_W-1:0]          limit_reg, limit_next;
    logic [AW-1:0]             wp_reg, wp_next;
    logic [AW-1:0]             rp_reg, rp_next;
    logic [LEN_W-1:0]          rem_reg, rem_next;
    logic                      reach_reg, reach_next;
    logic                      dist1_reg, dist1_next;
    logic                      lastblk_reg, lastblk_next;
    logic                      inflight_reg, inflight_next;
    logic                      pend_reg, pend_next;
    logic                      fin_reg, fin_next;
    logic [NUM_LANES-1:0][7:0] pack_reg, pack_next;
    logic [BYTE_CNT_W-1:0]     pack_cnt_reg, pack_cnt_next;
    logic [7:0]                last_byte_reg, last_byte_next;
    result_t                   out_reg, out_next;
    logic                      out_valid_reg, out_valid_next;

    logic                      ram_we;
    logic [AW-1:0]             ram_wa;
    logic [7:0]                ram_wd;
    logic                      ram_re;
    logic [AW-1:0]             ram_ra;
    logic [7:0]                ram_rd;

    logic                      out_free;
    logic                      acc;
    logic                      emit_lit;
    logic                      clear;
    logic [16:0]               back_dist;
    logic [CNT_W-1:0]          room;
    logic [LEN_W-1:0]          rem_new;
    logic [AW:0]               rp_full;
    logic [7:0]                copy_byte;
    logic [NUM_LANES-1:0][7:0] pack_after;
    logic [BYTE_CNT_W-1:0]     cnt_after;
    logic [CNT_W-1:0]          wc_after;
    logic                      final_b;
    logic                      flush_req;
    logic                      fin;

    asd_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW_DEPTH)
    ) u_hist (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_wa),
        .wr_data (ram_wd),
        .rd_en   (ram_re),
        .rd_addr (ram_ra),
        .rd_data (ram_rd)
    );

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && out_free;
    assign acc           = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        lit_left_next  = lit_left_reg;
        match_len_next = match_len_reg;
        off_high_next  = off_high_reg;
        written_next   = written_reg;
        limit_next     = cfg_wr_en ? cfg_wr_data : limit_reg;
        wp_next        = wp_reg;
        rp_next        = rp_reg;
        rem_next       = rem_reg;
        reach_next     = reach_reg;
        dist1_next     = dist1_reg;
        lastblk_next   = lastblk_reg;
        inflight_next  = inflight_reg;
        pend_next      = pend_reg;
        fin_next       = fin_reg;
        pack_next      = pack_reg;
        pack_cnt_next  = pack_cnt_reg;
        last_byte_next = last_byte_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;

        ram_we = 1'b0;
        ram_wa = wp_reg;
        ram_wd = '0;
        ram_re = 1'b0;
        ram_ra = rp_reg;

        emit_lit   = 1'b0;
        clear      = 1'b0;
        back_dist  = {1'b0, off_high_reg, s_axis_tdata} + 17'd1;
        room       = (limit_reg > written_reg) ? limit_reg - written_reg : '0;
        rem_new    = (room < CNT_W'(match_len_reg)) ? room[LEN_W-1:0] : match_len_reg;
        rp_full    = (wp_reg < AW'(back_dist))
                     ? ({1'b0, wp_reg} + DEPTH_EXT) - (AW+1)'(back_dist)
                     : {1'b0, wp_reg} - (AW+1)'(back_dist);
        copy_byte  = !reach_reg ? 8'h00 : (dist1_reg ? last_byte_reg : ram_rd);
        pack_after = pack_reg;
        cnt_after  = pack_cnt_reg;
        wc_after   = written_reg;
        final_b    = 1'b0;
        flush_req  = 1'b0;
        fin        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    clear = s_axis_tlast;
                    unique case (phase_reg)
                        PH_CODE:
                        begin
                            if ((s_axis_tdata & LIT_FLAG) != '0)
                            begin
                                lit_left_next = LEN_W'(s_axis_tdata & LIT_LEN_MASK);
                                phase_next    = PH_LIT;
                            end
                            else if ((s_axis_tdata & KIND_MASK) == '0)
                            begin
                                match_len_next = LEN_W'(((s_axis_tdata & SHORT_LEN_MASK) >> 2)
                                                        + SHORT_LEN_BIAS);
                                off_high_next  = s_axis_tdata & SHORT_OFF_MASK;
                                phase_next     = PH_OFFLO;
                            end
                            else
                            begin
                                match_len_next = LEN_W'((s_axis_tdata & LONG_LEN_MASK)
                                                        + LONG_LEN_BIAS);
                                phase_next     = PH_OFFHI;
                            end
                        end
                        PH_LIT:
                        begin
                            if (written_reg < limit_reg)
                            begin
                                ram_we         = 1'b1;
                                ram_wd         = s_axis_tdata;
                                wp_next        = wrap_inc(wp_reg);
                                written_next   = written_reg + 1'b1;
                                last_byte_next = s_axis_tdata;
                                emit_lit       = 1'b1;
                            end
                            if (lit_left_reg == '0)
                            begin
                                phase_next = PH_CODE;
                            end
                            else
                            begin
                                lit_left_next = lit_left_reg - 1'b1;
                            end
                        end
                        PH_OFFHI:
                        begin
                            off_high_next = s_axis_tdata;
                            phase_next    = PH_OFFLO;
                        end
                        PH_OFFLO:
                        begin
                            phase_next = PH_CODE;
                            if (rem_new != '0)
                            begin
                                state_next    = ST_COPY;
                                rem_next      = rem_new;
                                reach_next    = CNT_W'(back_dist) <= written_reg;
                                dist1_next    = (back_dist == 17'd1);
                                rp_next       = rp_full[AW-1:0];
                                lastblk_next  = s_axis_tlast;
                                pack_cnt_next = '0;
                                inflight_next = 1'b0;
                                pend_next     = 1'b0;
                                clear         = 1'b0;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_CODE;
                        end
                    endcase

                    if (emit_lit)
                    begin
                        out_next.bytes      = {24'h0, s_axis_tdata};
                        out_next.count      = BYTE_CNT_W'(1);
                        out_next.run_last   = 1'b1;
                        out_next.block_done = s_axis_tlast;
                        out_next.total      = written_reg + 1'b1;
                        out_valid_next      = 1'b1;
                    end
                    else if (clear)
                    begin
                        out_next.bytes      = '0;
                        out_next.count      = '0;
                        out_next.run_last   = 1'b1;
                        out_next.block_done = 1'b1;
                        out_next.total      = written_reg;
                        out_valid_next      = 1'b1;
                    end
                end
            end
            ST_COPY:
            begin
                if (inflight_reg)
                begin
                    pack_after[pack_cnt_reg[1:0]] = copy_byte;
                    cnt_after      = pack_cnt_reg + 1'b1;
                    wc_after       = written_reg + 1'b1;
                    written_next   = wc_after;
                    ram_we         = 1'b1;
                    ram_wd         = copy_byte;
                    wp_next        = wrap_inc(wp_reg);
                    last_byte_next = copy_byte;
                    inflight_next  = 1'b0;
                    final_b        = (rem_reg == '0);
                end
                flush_req = pend_reg || (inflight_reg && ((cnt_after == PER_CNT) || final_b));
                fin       = pend_reg ? fin_reg : final_b;
                pack_next     = pack_after;
                pack_cnt_next = cnt_after;

                if (flush_req)
                begin
                    if (out_free)
                    begin
                        for (int k = 0; k < NUM_LANES; k++)
                        begin
                            out_next.bytes[k] = (BYTE_CNT_W'(k) < cnt_after) ? pack_after[k]
                                                                               : 8'h00;
                        end
                        out_next.count      = cnt_after;
                        out_next.run_last   = fin;
                        out_next.block_done = fin && lastblk_reg;
                        out_next.total      = wc_after;
                        out_valid_next      = 1'b1;
                        pack_cnt_next       = '0;
                        pend_next           = 1'b0;
                        if (fin)
                        begin
                            state_next = ST_IDLE;
                            clear      = lastblk_reg;
                        end
                    end
                    else
                    begin
                        pend_next = 1'b1;
                        fin_next  = fin;
                    end
                end

                if ((rem_reg != '0) && (!flush_req || out_free))
                begin
                    ram_re        = 1'b1;
                    rp_next       = wrap_inc(rp_reg);
                    rem_next      = rem_reg - 1'b1;
                    inflight_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (clear)
        begin
            written_next   = '0;
            wp_next        = '0;
            phase_next     = PH_CODE;
            lit_left_next  = '0;
            match_len_next = '0;
            off_high_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_CODE;
            lit_left_reg  <= '0;
            match_len_reg <= '0;
            off_high_reg  <= '0;
            written_reg   <= '0;
            limit_reg     <= OUT_LIMIT_RST;
            wp_reg        <= '0;
            rem_reg       <= '0;
            reach_reg     <= 1'b0;
            dist1_reg     <= 1'b0;
            lastblk_reg   <= 1'b0;
            inflight_reg  <= 1'b0;
            pend_reg      <= 1'b0;
            fin_reg       <= 1'b0;
            pack_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            lit_left_reg  <= lit_left_next;
            match_len_reg <= match_len_next;
            off_high_reg  <= off_high_next;
            written_reg   <= written_next;
            limit_reg     <= limit_next;
            wp_reg        <= wp_next;
            rem_reg       <= rem_next;
            reach_reg     <= reach_next;
            dist1_reg     <= dist1_next;
            lastblk_reg   <= lastblk_next;
            inflight_reg  <= inflight_next;
            pend_reg      <= pend_next;
            fin_reg       <= fin_next;
            pack_cnt_reg  <= pack_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rp_reg        <= rp_next;
        pack_reg      <= pack_next;
        last_byte_reg <= last_byte_next;
        out_reg       <= out_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.total, out_reg.count, out_reg.bytes};
    assign m_axis_tlast  = out_reg.run_last;
    assign m_axis_tuser  = out_reg.block_done;

    // a held pack never has a read in flight behind it
    a_pend_no_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> !inflight_reg)
        else $error("pack held with a read in flight");

    // an empty beat only ever closes a block
    a_empty_is_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.count == '0)) |-> (out_reg.block_done && out_reg.run_last))
        else $error("empty beat without block_done");

    a_pack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pack_cnt_reg <= PER_CNT)
        else $error("pack count beyond beat width");

    // the end of a block clears the byte count
    a_block_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && s_axis_tlast && (state_next == ST_IDLE)) |=> (written_reg == '0))
        else $error("byte count not cleared at end of block");

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
module tb_top;
    import asd_pkg::*;

    typedef struct {
        logic [7:0] code;
        logic       last;
    } comp_beat_t;

    typedef struct {
        logic [7:0]       b [4];
        logic [2:0]       count;
        logic             run_last;
        logic             done;
        logic [CNT_W-1:0] total;
    } decoded_beat_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [CNT_W-1:0]  cfg_wr_data;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata;
    logic              s_axis_tlast;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [55:0]       m_axis_tdata;
    logic              m_axis_tlast;
    logic              m_axis_tuser;

    adc_stream_decompressor_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // decoder mirror
    logic [7:0]  hist [0:65535];
    int unsigned wcnt;
    int unsigned limit_val;
    phase_t      ph;
    int unsigned lit_left;
    int unsigned mlen;
    int unsigned off_hi;
    logic [7:0]  step_q [$];

    comp_beat_t    pend_q [$];
    decoded_beat_t decoded_q [$];

    int unsigned n_in;
    int unsigned n_out;
    int unsigned n_blocks;
    int unsigned n_mismatch;

    task automatic emit_byte(input logic [7:0] v);
        if (wcnt < limit_val)
        begin
            hist[wcnt[15:0]] = v;
            step_q.push_back(v);
            wcnt++;
        end
    endtask

    task automatic decode_beat(input logic [7:0] c, input logic last);
        int unsigned   start;
        int unsigned   back_dist;
        int unsigned   pos;
        int unsigned   cnt;
        int unsigned   base;
        logic          reach;
        decoded_beat_t r;
        int            nres;
        start = wcnt;
        step_q.delete();
        case (ph)
            PH_CODE:
            begin
                if ((c & LIT_FLAG) != 0)
                begin
                    lit_left = c & LIT_LEN_MASK;
                    ph = PH_LIT;
                end
                else if ((c & KIND_MASK) == 0)
                begin
                    mlen = ((c & SHORT_LEN_MASK) >> 2) + 3;
                    off_hi = c & SHORT_OFF_MASK;
                    ph = PH_OFFLO;
                end
                else
                begin
                    mlen = (c & LONG_LEN_MASK) + 4;
                    ph = PH_OFFHI;
                end
            end
            PH_LIT:
            begin
                emit_byte(c);
                if (lit_left == 0)
                    ph = PH_CODE;
                else
                    lit_left--;
            end
            PH_OFFHI:
            begin
                off_hi = c;
                ph = PH_OFFLO;
            end
            default:
            begin
                back_dist = ((off_hi & 8'hff) << 8 | c) + 1;
                reach = back_dist <= wcnt;
                for (int i = 0; i < mlen; i++)
                begin
                    base = wcnt - back_dist;
                    emit_byte(reach ? hist[base[15:0]] : 8'h00);
                end
                ph = PH_CODE;
            end
        endcase
        pos = 0;
        nres = 0;
        while (pos < step_q.size())
        begin
            cnt = step_q.size() - pos;
            if (cnt > 4)
                cnt = 4;
            for (int k = 0; k < 4; k++)
                r.b[k] = (k < cnt) ? step_q[pos + k] : 8'h00;
            pos += cnt;
            r.count = 3'(cnt);
            r.run_last = (pos == step_q.size());
            r.done = 1'b0;
            r.total = CNT_W'(start + pos);
            decoded_q.push_back(r);
            nres++;
        end
        if (last)
        begin
            if (nres == 0)
            begin
                for (int k = 0; k < 4; k++)
                    r.b[k] = 8'h00;
                r.count = '0;
                r.run_last = 1'b1;
                r.total = CNT_W'(wcnt);
                r.done = 1'b1;
                decoded_q.push_back(r);
            end
            else
                decoded_q[decoded_q.size() - 1].done = 1'b1;
            wcnt = 0;
            ph = PH_CODE;
            lit_left = 0;
            mlen = 0;
            off_hi = 0;
            n_blocks++;
        end
    endtask

    // sender with bursts and gaps
    int unsigned burst_left;
    int unsigned gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        logic busy;
        comp_beat_t it;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'h00;
            s_axis_tlast  <= 1'b0;
            burst_left = 8;
            gap_left = 0;
        end
        else
        begin
            busy = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready)
            begin
                decode_beat(s_axis_tdata, s_axis_tlast);
                n_in++;
                busy = 1'b0;
            end
            if (!busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pend_q.size() > 0)
                begin
                    it = pend_q.pop_front();
                    s_axis_tdata  <= it.code;
                    s_axis_tlast  <= it.last;
                    s_axis_tvalid <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 30);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                    end
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver stalls
    int unsigned stall_left;
    int unsigned calm_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
            calm_left = 0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else if (calm_left > 0)
        begin
            calm_left--;
            m_axis_tready <= 1'b1;
        end
        else
        begin
            case ($urandom_range(0, 15))
                0: calm_left = $urandom_range(20, 150);
                1, 2, 3: stall_left = $urandom_range(1, 12);
                default: ;
            endcase
            m_axis_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        decoded_beat_t e;
        logic [7:0] ab [4];
        logic [2:0] acnt;
        logic [CNT_W-1:0] atot;
        logic bad;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            for (int k = 0; k < 4; k++)
                ab[k] = m_axis_tdata[8*k +: 8];
            acnt = m_axis_tdata[34:32];
            atot = m_axis_tdata[55:35];
            n_out++;
            if (decoded_q.size() == 0)
            begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected beat: tdata=%h last=%b done=%b",
                             m_axis_tdata, m_axis_tlast, m_axis_tuser);
            end
            else
            begin
                e = decoded_q.pop_front();
                bad = (acnt != e.count) || (atot != e.total)
                      || (m_axis_tlast != e.run_last) || (m_axis_tuser != e.done);
                for (int k = 0; k < 4; k++)
                    if (ab[k] != e.b[k])
                        bad = 1'b1;
                if (bad)
                begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                    begin
                        $display("mismatch: exp %h %h %h %h cnt=%0d last=%b done=%b tot=%0d",
                                 e.b[0], e.b[1], e.b[2], e.b[3], e.count, e.run_last,
                                 e.done, e.total);
                        $display("          act %h %h %h %h cnt=%0d last=%b done=%b tot=%0d",
                                 ab[0], ab[1], ab[2], ab[3], acnt,
                                 m_axis_tlast, m_axis_tuser, atot);
                    end
                end
            end
        end
    end

    task automatic push_code(input logic [7:0] c, input logic l = 1'b0);
        comp_beat_t it;
        it.code = c;
        it.last = l;
        pend_q.push_back(it);
    endtask

    // builds one compressed block, mostly well formed
    task automatic gen_block(input int unsigned n_codes);
        int unsigned gw;
        int unsigned len;
        int unsigned back_dist;
        int unsigned kind;
        int unsigned m;
        gw = 0;
        for (int i = 0; i < n_codes; i++)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 4 || gw == 0)
            begin
                len = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 128)
                                                    : $urandom_range(1, 6);
                push_code(8'(8'h80 | (len - 1)));
                for (int j = 0; j < len; j++)
                    push_code(8'($urandom_range(0, 255)));
                gw += len;
            end
            else if (kind < 7)
            begin
                len = $urandom_range(3, 18);
                m = (gw < 1024) ? gw : 1024;
                back_dist = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 1024)
                                                        : $urandom_range(1, m);
                push_code(8'(((len - 3) << 2) | ((back_dist - 1) >> 8)));
                push_code(8'((back_dist - 1) & 8'hff));
                gw += len;
            end
            else if (kind < 9)
            begin
                len = $urandom_range(4, 67);
                back_dist = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 65536)
                                                        : $urandom_range(1, gw);
                push_code(8'(8'h40 | (len - 4)));
                push_code(8'((back_dist - 1) >> 8));
                push_code(8'((back_dist - 1) & 8'hff));
                gw += len;
            end
            else
                push_code(8'($urandom_range(0, 255)));
        end
        // end either cleanly or cut inside a code
        if ($urandom_range(0, 3) == 0)
            push_code(8'($urandom_range(0, 255)), 1'b1);
        else
        begin
            len = $urandom_range(1, 4);
            push_code(8'(8'h80 | (len - 1)));
            for (int j = 0; j < len; j++)
                push_code(8'($urandom_range(0, 255)), j == len - 1);
        end
    endtask

    task automatic drain_and_settle;
        while (pend_q.size() > 0 || s_axis_tvalid || decoded_q.size() > 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_limit(input int unsigned v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= CNT_W'(v);
        limit_val = v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial
    begin
        int unsigned limits [5];
        int unsigned target;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        wcnt = 0;
        limit_val = OUT_LIMIT_RST;
        ph = PH_CODE;
        lit_left = 0;
        mlen = 0;
        off_hi = 0;
        n_in = 0;
        n_out = 0;
        n_blocks = 0;
        n_mismatch = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: literals, overlapping match, matches before start, cut codes
        push_code(8'h82);
        push_code(8'h00);
        push_code(8'hff);
        push_code(8'ha5);
        push_code(8'h00);
        push_code(8'h00);
        push_code(8'h3f);
        push_code(8'h02);
        push_code(8'h3f);
        push_code(8'hff);
        push_code(8'h7f);
        push_code(8'hff);
        push_code(8'hff);
        push_code(8'h40);
        push_code(8'h00);
        push_code(8'h00, 1'b1);
        push_code(8'h40, 1'b1);
        push_code(8'hff);
        push_code(8'h5a, 1'b1);
        push_code(8'h85, 1'b1);
        push_code(8'h00);
        push_code(8'h3c, 1'b1);
        drain_and_settle();

        limits[0] = OUT_LIMIT_RST;
        limits[1] = 1;
        limits[2] = 1048576;
        limits[3] = $urandom_range(5, 60);
        limits[4] = $urandom_range(100, 400);
        for (int p = 0; p < 5; p++)
        begin
            write_limit(limits[p]);
            target = pend_q.size() + 60;
            while (pend_q.size() < target)
                gen_block($urandom_range(1, 8));
            drain_and_settle();
        end

        $display("%0d compressed beats in %0d blocks, %0d decoded beats checked",
                 n_in, n_blocks, n_out);
        $display("out_limit settings: 65536, 1, 1048576, %0d, %0d", limits[3], limits[4]);
        if (n_mismatch == 0 && decoded_q.size() == 0)
            $display("adc_stream_decompressor_core regression: pass");
        else
            $display("adc_stream_decompressor_core regression: fail");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("adc_stream_decompressor_core regression: fail");
        $finish;
    end

endmodule

// ===== adc_stream_decompressor_core.f =====
design/asd_pkg.sv
design/asd_ram.sv
design/adc_stream_decompressor_core.sv
tb/tb_top.sv
